[hw/rtl/siq_pkg.sv]
// ----------------------------------------------------------------------------
// siq_pkg: shared definitions for the sorted insertion priority queue
// Queue sizing, command and status codes, and the cell control bundle.
// ----------------------------------------------------------------------------
package siq_pkg;

    localparam int DEPTH       = 8;
    localparam int VALUE_WIDTH = 32;
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;

    localparam int IN_BITS     = CMD_W + VALUE_WIDTH;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = STATUS_W + VALUE_WIDTH + OCC_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Per-cycle command to every cell of the chain
    typedef struct packed {
        logic ins;  // insert the incoming value in sorted position
        logic shl;  // shift one place toward the head
    } t_cell_ctrl;

endpackage

[hw/rtl/sorted_insertion_priority_queue_core.sv]
// ----------------------------------------------------------------------------
// sorted_insertion_priority_queue_core: bounded ascending priority queue
// The cell chain registers each insert or shift together with its result.
// Throughput: one command per cycle unless the master side stalls, and the
// output register is refilled as it is drained.
// Reset: synchronous active-low i_rst_n empties the queue and drops the
// pending result; stored values are left as they are.
// ----------------------------------------------------------------------------
module sorted_insertion_priority_queue_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // command[1:0], value[33:2], zero pad above
    input  logic [siq_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // status[1:0], data[33:2], occupancy[37:34], zero pad above
    output logic [siq_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    localparam int VW = siq_pkg::VALUE_WIDTH;
    localparam int DP = siq_pkg::DEPTH;
    localparam int OW = siq_pkg::OCC_W;

    logic [siq_pkg::CMD_W-1:0]  w_cmd;
    logic signed [VW-1:0]       w_new;
    logic                       w_accept;
    logic                       w_full;
    logic                       w_empty;
    siq_pkg::t_cell_ctrl        w_ctrl;

    logic signed [VW-1:0]       w_val [DP];
    logic [DP-1:0]              w_gt;
    logic [DP-1:0]              w_occ;

    logic [OW-1:0]              r_cnt;
    logic [OW-1:0]              n_cnt;
    logic                       r_m_valid;
    logic [siq_pkg::OUT_TDATA_W-1:0] r_m_data;
    logic [siq_pkg::STATUS_W-1:0] w_status;
    logic signed [VW-1:0]       w_data;

    assign w_cmd = s_axis_tdata[siq_pkg::CMD_W-1:0];
    assign w_new = s_axis_tdata[siq_pkg::CMD_W +: VW];

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_cnt == OW'(DP));
    assign w_empty       = (r_cnt == '0);

    assign w_ctrl.ins = w_accept && (w_cmd == siq_pkg::CMD_ENQUEUE) && !w_full;
    assign w_ctrl.shl = w_accept && (w_cmd == siq_pkg::CMD_DEQUEUE) && !w_empty;

    genvar gi;
    generate
        for (gi = 0; gi < DP; gi++) begin : g_cell
            logic signed [VW-1:0] w_prev_val;
            logic signed [VW-1:0] w_next_val;
            logic                 w_prev_gt;
            logic                 w_prev_occ;

            assign w_occ[gi] = (r_cnt > OW'(gi));

            if (gi == 0) begin : g_head
                assign w_prev_val = w_new;
                assign w_prev_gt  = 1'b0;
                assign w_prev_occ = 1'b1;
            end else begin : g_body
                assign w_prev_val = w_val[gi-1];
                assign w_prev_gt  = w_gt[gi-1];
                assign w_prev_occ = w_occ[gi-1];
            end

            if (gi == DP - 1) begin : g_tail
                assign w_next_val = w_val[gi];
            end else begin : g_link
                assign w_next_val = w_val[gi+1];
            end

            siq_cell u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_ctrl),
                .i_new_val  (w_new),
                .i_prev_val (w_prev_val),
                .i_prev_gt  (w_prev_gt),
                .i_prev_occ (w_prev_occ),
                .i_next_val (w_next_val),
                .i_occ      (w_occ[gi]),
                .o_val      (w_val[gi]),
                .o_gt       (w_gt[gi])
            );
        end
    endgenerate

    always_comb begin
        w_status = siq_pkg::ST_OK;
        w_data   = '0;
        n_cnt    = r_cnt;
        case (w_cmd)
            siq_pkg::CMD_ENQUEUE: begin
                if (w_full) begin
                    w_status = siq_pkg::ST_FULL;
                end else begin
                    n_cnt = r_cnt + OW'(1);
                end
            end
            siq_pkg::CMD_DEQUEUE: begin
                if (w_empty) begin
                    w_status = siq_pkg::ST_EMPTY;
                end else begin
                    w_data = w_val[0];
                    n_cnt  = r_cnt - OW'(1);
                end
            end
            siq_pkg::CMD_PEEK: begin
                if (w_empty) begin
                    w_status = siq_pkg::ST_EMPTY;
                end else begin
                    w_data = w_val[0];
                end
            end
            default: begin
                // unused code: report occupancy, change nothing
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_cnt     <= n_cnt;
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= siq_pkg::OUT_TDATA_W'({n_cnt, w_data, w_status});
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule

[hw/rtl/siq_cell.sv]
// ----------------------------------------------------------------------------
// siq_cell: one slot of the sorted queue
// Holds one value, flags whether it is greater than the incoming value, and
// takes the new value, its left or right neighbor's value, or holds.
// ----------------------------------------------------------------------------
module siq_cell (
    input  logic                                 i_clk,
    input  siq_pkg::t_cell_ctrl                  i_ctrl,
    input  logic signed [siq_pkg::VALUE_WIDTH-1:0] i_new_val,
    input  logic signed [siq_pkg::VALUE_WIDTH-1:0] i_prev_val,
    input  logic                                 i_prev_gt,
    input  logic                                 i_prev_occ,
    input  logic signed [siq_pkg::VALUE_WIDTH-1:0] i_next_val,
    input  logic                                 i_occ,
    output logic signed [siq_pkg::VALUE_WIDTH-1:0] o_val,
    output logic                                 o_gt
);

    logic signed [siq_pkg::VALUE_WIDTH-1:0] r_val;
    logic signed [siq_pkg::VALUE_WIDTH-1:0] n_val;

    // Strictly greater: equal values stay ahead of the newcomer
    assign o_gt  = i_occ && (r_val > i_new_val);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctrl.ins) begin
            if (i_prev_gt) begin
                n_val = i_prev_val;
            end else if (o_gt || (!i_occ && i_prev_occ)) begin
                n_val = i_new_val;
            end
        end else if (i_ctrl.shl) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

[bench/sorted_insertion_priority_queue_core_tb.sv]
// ----------------------------------------------------------------------------
// sorted_insertion_priority_queue_core_tb: stream-level check of the queue
// Drives enqueue, dequeue, peek and unused commands with random gaps on
// both sides, predicts every result from a software copy of the sorted
// store, and compares status, data and occupancy of each result in order.
// ----------------------------------------------------------------------------
module sorted_insertion_priority_queue_core_tb;

    localparam logic [siq_pkg::CMD_W-1:0] CMD_UNUSED   = 2'd3;
    localparam int                        LONG_STALL   = 200;
    localparam int                        IDLE_LIMIT   = 5000;
    localparam int                        DRAIN_CYCLES = 8;
    localparam int                        MAX_REPORTS  = 10;

    typedef struct {
        logic [siq_pkg::STATUS_W-1:0]    status;
        logic [siq_pkg::VALUE_WIDTH-1:0] data;
        logic [siq_pkg::OCC_W-1:0]       occupancy;
    } t_queue_result;

    // Mirror of the sorted store; predicts one result per accepted command
    class queue_result_checker;
        logic signed [siq_pkg::VALUE_WIDTH-1:0] slots [siq_pkg::DEPTH];
        int                                     fill;
        t_queue_result                          awaited [$];
        int                                     error_count;

        function new();
            fill        = 0;
            error_count = 0;
        endfunction

        function void flag_error(string what, t_queue_result exp, t_queue_result got);
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("%0t: %s: expected status %0d data %0d occ %0d,",
                         $time, what, exp.status, $signed(exp.data), exp.occupancy,
                         " got status %0d data %0d occ %0d",
                         got.status, $signed(got.data), got.occupancy);
            end
        endfunction

        function void accept_command(logic [siq_pkg::CMD_W-1:0] cmd,
                                     logic signed [siq_pkg::VALUE_WIDTH-1:0] value);
            t_queue_result r;
            int            pos;
            r.status = siq_pkg::ST_OK;
            r.data   = '0;
            case (cmd)
                siq_pkg::CMD_ENQUEUE: begin
                    if (fill >= siq_pkg::DEPTH) begin
                        r.status = siq_pkg::ST_FULL;
                    end else begin
                        // equal values stay ahead of the newcomer
                        pos = fill;
                        while (pos > 0 && slots[pos-1] > value) begin
                            slots[pos] = slots[pos-1];
                            pos--;
                        end
                        slots[pos] = value;
                        fill++;
                    end
                end
                siq_pkg::CMD_DEQUEUE, siq_pkg::CMD_PEEK: begin
                    if (fill == 0) begin
                        r.status = siq_pkg::ST_EMPTY;
                    end else begin
                        r.data = slots[0];
                        if (cmd == siq_pkg::CMD_DEQUEUE) begin
                            for (int k = 1; k < fill; k++) slots[k-1] = slots[k];
                            fill--;
                        end
                    end
                end
                default: ;
            endcase
            r.occupancy = siq_pkg::OCC_W'(fill);
            awaited.push_back(r);
        endfunction

        function void check_result(logic [siq_pkg::OUT_TDATA_W-1:0] word);
            t_queue_result got;
            t_queue_result exp;
            got.status    = word[siq_pkg::STATUS_W-1:0];
            got.data      = word[siq_pkg::STATUS_W +: siq_pkg::VALUE_WIDTH];
            got.occupancy = word[siq_pkg::STATUS_W+siq_pkg::VALUE_WIDTH +: siq_pkg::OCC_W];
            if (awaited.size() == 0) begin
                exp = '{default: '0};
                flag_error("result with no command pending", exp, got);
                return;
            end
            exp = awaited.pop_front();
            if (got.status !== exp.status || got.data !== exp.data
                || got.occupancy !== exp.occupancy) begin
                flag_error("result mismatch", exp, got);
            end
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void close_out();
            if (awaited.size() != 0) begin
                error_count++;
                $display("%0t: %0d results never arrived", $time, awaited.size());
            end
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [siq_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // command, value, zero pad
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [siq_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // status, data, occupancy, zero pad

    queue_result_checker queue_check = new();
    int                  idle_cycles = 0;
    bit                  steady_flow = 1'b0;
    bit                  hold_request = 1'b0;
    bit                  hold_active  = 1'b0;

    sorted_insertion_priority_queue_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one; none in a steady stretch
    function automatic int gap_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [siq_pkg::CMD_W-1:0] pick_command(int enq_pct);
        int r;
        if ($urandom_range(0, 99) < 2) return CMD_UNUSED;
        r = $urandom_range(0, 99);
        if (r < enq_pct) return siq_pkg::CMD_ENQUEUE;
        if (r < enq_pct + (100 - enq_pct) * 3 / 4) return siq_pkg::CMD_DEQUEUE;
        return siq_pkg::CMD_PEEK;
    endfunction

    function automatic logic [siq_pkg::VALUE_WIDTH-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return $urandom;
        // narrow range to get plenty of ties
        if (r < 8) return siq_pkg::VALUE_WIDTH'($signed($urandom_range(0, 8)) - 4);
        case ($urandom_range(0, 3))
            0:       return {1'b1, {(siq_pkg::VALUE_WIDTH-1){1'b0}}};
            1:       return {1'b0, {(siq_pkg::VALUE_WIDTH-1){1'b1}}};
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic send_command(input logic [siq_pkg::CMD_W-1:0] cmd,
                                input logic [siq_pkg::VALUE_WIDTH-1:0] value);
        int gap;
        gap = gap_cycles();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(siq_pkg::IN_TDATA_W-siq_pkg::IN_BITS){1'b0}}, value, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Keep offering commands while the receiver holds off, then drain fully
    task automatic apply_backpressure();
        hold_request = 1'b1;
        while (!hold_active) @(posedge i_clk);
        steady_flow = 1'b1;
        repeat (40) send_command(pick_command(60), pick_value());
        steady_flow = 1'b0;
        s_axis_tvalid <= 1'b0;
        while (queue_check.pending() != 0) @(posedge i_clk);
    endtask

    // Result side: random stalls, plus one long hold on request
    initial begin
        int n;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                hold_active = 1'b0;
            end
            n = gap_cycles();
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Sample both transaction sides; inputs change only after this edge
    always @(posedge i_clk) begin
        bit moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                queue_check.accept_command(s_axis_tdata[siq_pkg::CMD_W-1:0],
                                           s_axis_tdata[siq_pkg::CMD_W +: siq_pkg::VALUE_WIDTH]);
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                queue_check.check_result(m_axis_tdata);
                moved = 1'b1;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    initial begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int enq_pct;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue, unused code, fill with extremes and ties, overflow, drain past empty
        send_command(siq_pkg::CMD_PEEK, '0);
        send_command(siq_pkg::CMD_DEQUEUE, '1);
        send_command(CMD_UNUSED, 32'h1234_5678);
        send_command(siq_pkg::CMD_ENQUEUE, 32'h7FFF_FFFF);
        send_command(siq_pkg::CMD_ENQUEUE, 32'h8000_0000);
        send_command(siq_pkg::CMD_ENQUEUE, 32'h0000_0000);
        send_command(siq_pkg::CMD_ENQUEUE, 32'hFFFF_FFFF);
        send_command(siq_pkg::CMD_ENQUEUE, 32'd5);
        send_command(siq_pkg::CMD_ENQUEUE, 32'd5);
        send_command(siq_pkg::CMD_ENQUEUE, 32'hAAAA_AAAA);
        send_command(siq_pkg::CMD_ENQUEUE, 32'h5555_5555);
        send_command(siq_pkg::CMD_ENQUEUE, 32'd1);
        send_command(CMD_UNUSED, '0);
        send_command(siq_pkg::CMD_PEEK, '0);
        repeat (9) send_command(siq_pkg::CMD_DEQUEUE, '0);

        for (int blk = 0; blk < 46; blk++) begin
            if (blk == 23) apply_backpressure();
            steady_flow = ($urandom_range(0, 5) == 0);
            case ($urandom_range(0, 2))
                0:       enq_pct = 85;
                1:       enq_pct = 50;
                default: enq_pct = 20;
            endcase
            repeat (40) send_command(pick_command(enq_pct), pick_value());
        end
        steady_flow = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (queue_check.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        queue_check.close_out();
        if (queue_check.error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
